>>> sv/bwc_pkg.sv
// Shared constants, item types and the case-fold function of the banned-word censor.
// No dependencies; bwc_front, bwc_back, the top level and the bench import it.
`default_nettype none
package bwc_pkg;
	localparam int MAX_WORDS    = 16;
	localparam int MAX_WORD_LEN = 16;
	localparam int CHAR_BITS    = 16;

	localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WCNT_W = $clog2(MAX_WORDS + 1);
	localparam int POS_W  = $clog2(MAX_WORD_LEN);
	localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
	localparam int ROW_W  = MAX_WORD_LEN * CHAR_BITS;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CHAR_BITS-1:0] ASTERISK = CHAR_BITS'('h2A);

	localparam logic [1:0] KIND_WORD  = 2'd0;
	localparam logic [1:0] KIND_TEXT  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] ST_TEXT   = 2'd0;
	localparam logic [1:0] ST_STORED = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	typedef enum logic [1:0] {OP_LOAD, OP_TEXT, OP_CLEAR} op_t;

	typedef struct packed {
		op_t                  op;
		logic [CHAR_BITS-1:0] ch;
		logic                 last;
	} item_t;

	// ASCII A-Z to lower case, everything else unchanged
	function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c);
		if (c >= CHAR_BITS'('h41) && c <= CHAR_BITS'('h5A))
			return c + CHAR_BITS'('h20);
		return c;
	endfunction
endpackage
`default_nettype wire

>>> sv/bwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/bwc_front.sv
// Front end: accepts input items, decodes the kind into an operation and queues them.
// Depends on bwc_pkg.
`default_nettype none
module bwc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     kind,
	input  logic [15:0]    char_code,
	input  logic           last,
	output logic           q_valid,
	output bwc_pkg::item_t q_item,
	input  logic           q_pop
);
	import bwc_pkg::*;

	item_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               xfer, push, do_pop;
	item_t              dec;

	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign xfer     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];
	assign do_pop   = q_pop && q_valid;

	always_comb begin
		dec.ch   = char_code[CHAR_BITS-1:0];
		dec.last = last;
		dec.op   = OP_TEXT;
		push     = xfer;
		case (kind)
			KIND_WORD:  dec.op = OP_LOAD;
			KIND_TEXT:  dec.op = OP_TEXT;
			KIND_CLEAR: dec.op = OP_CLEAR;
			default:    push = 1'b0; // unused kind: drop
		endcase
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end
endmodule
`default_nettype wire

>>> sv/bwc_back.sv
// Back end: loads words into the word RAM, matches text against every stored word
// one word per cycle, masks matched spans and emits results. Depends on bwc_pkg, bwc_ram.
`default_nettype none
module bwc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  bwc_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [15:0]    char_out,
	output logic           masked,
	output logic           last_out,
	output logic           found,
	output logic [1:0]     status
);
	import bwc_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_MATCH, B_EMIT} bstate_t;

	bstate_t              state_q;
	logic [CHAR_BITS-1:0] ld_buf_q  [MAX_WORD_LEN];
	logic [LEN_W-1:0]     ld_pos_q;
	logic                 ld_ovf_q;
	logic [WCNT_W-1:0]    wiu_q;
	logic [LEN_W-1:0]     wlen_q    [MAX_WORDS];
	logic [LEN_W-1:0]     skip_q    [MAX_WORDS];
	logic [CHAR_BITS-1:0] hist_q    [MAX_WORD_LEN];
	logic [CHAR_BITS-1:0] pend_ch_q [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] pend_m_q;
	logic [LEN_W-1:0]     pcnt_q, seen_q;
	logic                 found_q, emit_all_q;
	logic [WCNT_W-1:0]    rd_idx_q;
	logic                 v_s1;
	logic [WIDX_W-1:0]    idx_s1;

	logic                 out_valid_q, o_masked_q, o_last_q, o_found_q;
	logic [CHAR_BITS-1:0] o_char_q;
	logic [1:0]           o_status_q;

	logic                 out_free, ld_store, ld_ovf_n, ram_we, rd_more, cand, hit, emit_go;
	logic [LEN_W-1:0]     ld_pos_n, cur_len, cur_skip;
	logic [CHAR_BITS-1:0] buf_n [MAX_WORD_LEN];
	logic [CHAR_BITS-1:0] text_f;
	logic [ROW_W-1:0]     wdata, row;
	logic [MAX_WORD_LEN-1:0] ok, mask_set;
	logic [POS_W-1:0]     app_idx;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == B_IDLE) && q_valid && out_free;
	assign text_f   = fold(q_item.ch);

	// word load
	assign ld_store = (ld_pos_q < LEN_W'(MAX_WORD_LEN)) && (wiu_q < WCNT_W'(MAX_WORDS));
	assign ld_pos_n = ld_pos_q + LEN_W'(ld_store);
	assign ld_ovf_n = ld_ovf_q | !ld_store;
	assign ram_we   = q_pop && (q_item.op == OP_LOAD) && q_item.last && !ld_ovf_n;

	// the buffer shifts in at the top, so a word ends up right-aligned in its row
	always_comb begin
		for (int p = 0; p < MAX_WORD_LEN; p++) begin
			if (!ld_store)
				buf_n[p] = ld_buf_q[p];
			else if (p == MAX_WORD_LEN - 1)
				buf_n[p] = text_f;
			else
				buf_n[p] = ld_buf_q[p+1];
			wdata[p*CHAR_BITS +: CHAR_BITS] = buf_n[p];
		end
	end

	assign rd_more = (rd_idx_q < wiu_q);

	bwc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WORDS)) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wiu_q[WIDX_W-1:0]),
		.wdata (wdata),
		.raddr (rd_idx_q[WIDX_W-1:0]),
		.rdata (row)
	);

	// compare stage
	assign cur_len  = wlen_q[idx_s1];
	assign cur_skip = skip_q[idx_s1];
	always_comb begin
		for (int p = 0; p < MAX_WORD_LEN; p++) begin
			ok[p] = ((LEN_W+1)'(p) + (LEN_W+1)'(cur_len) < (LEN_W+1)'(MAX_WORD_LEN))
				|| (row[p*CHAR_BITS +: CHAR_BITS] == hist_q[p]);
			mask_set[p] = ((LEN_W+1)'(p) + (LEN_W+1)'(cur_len) >= (LEN_W+1)'(pcnt_q))
				&& ((LEN_W+1)'(p) < (LEN_W+1)'(pcnt_q));
		end
	end
	assign cand = (cur_skip == '0) && (cur_len != '0) && (cur_len <= seen_q)
		&& (cur_len <= pcnt_q);
	assign hit  = v_s1 && cand && (&ok);

	assign app_idx = (pcnt_q >= LEN_W'(MAX_WORD_LEN)) ? POS_W'(MAX_WORD_LEN - 1)
		: pcnt_q[POS_W-1:0];
	assign emit_go = (pcnt_q != '0) && (emit_all_q || pcnt_q >= LEN_W'(MAX_WORD_LEN));

	always_ff @(posedge clk) begin
		if (q_pop && q_item.op == OP_LOAD)
			for (int p = 0; p < MAX_WORD_LEN; p++)
				ld_buf_q[p] <= buf_n[p];
		if (q_pop && q_item.op == OP_TEXT)
			pend_ch_q[app_idx] <= q_item.ch;
		else if (state_q == B_EMIT && emit_go && out_free)
			for (int p = 0; p < MAX_WORD_LEN - 1; p++)
				pend_ch_q[p] <= pend_ch_q[p+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			ld_pos_q    <= '0;
			ld_ovf_q    <= 1'b0;
			wiu_q       <= '0;
			pend_m_q    <= '0;
			pcnt_q      <= '0;
			seen_q      <= '0;
			found_q     <= 1'b0;
			emit_all_q  <= 1'b0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
			o_char_q    <= '0;
			o_masked_q  <= 1'b0;
			o_last_q    <= 1'b0;
			o_found_q   <= 1'b0;
			o_status_q  <= ST_TEXT;
			for (int i = 0; i < MAX_WORDS; i++) begin
				wlen_q[i] <= '0;
				skip_q[i] <= '0;
			end
			for (int p = 0; p < MAX_WORD_LEN; p++)
				hist_q[p] <= '0;
		end else begin
			if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						case (q_item.op)
							OP_LOAD: begin
								ld_pos_q <= ld_pos_n;
								ld_ovf_q <= ld_ovf_n;
								if (q_item.last) begin
									ld_pos_q    <= '0;
									ld_ovf_q    <= 1'b0;
									out_valid_q <= 1'b1;
									o_char_q    <= '0;
									o_masked_q  <= 1'b0;
									o_last_q    <= 1'b0;
									o_found_q   <= 1'b0;
									o_status_q  <= ST_REJECT;
									if (!ld_ovf_n) begin
										o_status_q <= ST_STORED;
										wlen_q[wiu_q[WIDX_W-1:0]] <= ld_pos_n;
										skip_q[wiu_q[WIDX_W-1:0]] <= '0;
										wiu_q <= wiu_q + WCNT_W'(1);
									end
								end
							end
							OP_TEXT: begin
								for (int p = 0; p < MAX_WORD_LEN - 1; p++)
									hist_q[p] <= hist_q[p+1];
								hist_q[MAX_WORD_LEN-1] <= text_f;
								pend_m_q[app_idx] <= 1'b0;
								pcnt_q <= LEN_W'(app_idx) + LEN_W'(1);
								if (seen_q < LEN_W'(MAX_WORD_LEN))
									seen_q <= seen_q + LEN_W'(1);
								emit_all_q <= q_item.last;
								rd_idx_q   <= '0;
								state_q    <= B_MATCH;
							end
							OP_CLEAR: begin
								wiu_q    <= '0;
								ld_pos_q <= '0;
								ld_ovf_q <= 1'b0;
								for (int i = 0; i < MAX_WORDS; i++) begin
									wlen_q[i] <= '0;
									skip_q[i] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				B_MATCH: begin
					// one RAM read per cycle, compared in the cycle after the read
					v_s1   <= rd_more;
					idx_s1 <= rd_idx_q[WIDX_W-1:0];
					if (rd_more)
						rd_idx_q <= rd_idx_q + WCNT_W'(1);
					if (v_s1) begin
						if (cur_skip != '0)
							skip_q[idx_s1] <= cur_skip - LEN_W'(1);
						else if (hit) begin
							skip_q[idx_s1] <= cur_len - LEN_W'(1);
							pend_m_q <= pend_m_q | mask_set;
							found_q  <= 1'b1;
						end
					end
					if (!rd_more && !v_s1)
						state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (!emit_go) begin
						if (emit_all_q) begin
							seen_q  <= '0;
							found_q <= 1'b0;
							for (int i = 0; i < MAX_WORDS; i++)
								skip_q[i] <= '0;
							for (int p = 0; p < MAX_WORD_LEN; p++)
								hist_q[p] <= '0;
						end
						state_q <= B_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						o_char_q    <= pend_m_q[0] ? ASTERISK : pend_ch_q[0];
						o_masked_q  <= pend_m_q[0];
						o_last_q    <= emit_all_q && (pcnt_q == LEN_W'(1));
						o_found_q   <= emit_all_q && (pcnt_q == LEN_W'(1)) && found_q;
						o_status_q  <= ST_TEXT;
						pend_m_q    <= pend_m_q >> 1;
						pcnt_q      <= pcnt_q - LEN_W'(1);
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = 16'(o_char_q);
	assign masked    = o_masked_q;
	assign last_out  = o_last_q;
	assign found     = o_found_q;
	assign status    = o_status_q;

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= LEN_W'(MAX_WORD_LEN)) else $error("pending count overrun");
	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> (pcnt_q < LEN_W'(MAX_WORD_LEN)))
		else $error("idle with full pending buffer");
	a_found_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_found_q) |-> o_last_q) else $error("found off last result");
	a_cmp_in_match: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == B_MATCH)) else $error("compare outside match");
	a_words_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wiu_q <= WCNT_W'(MAX_WORDS)) else $error("word count overrun");
endmodule
`default_nettype wire

>>> sv/bad_word_censor_unit.sv
// Top level of the banned-word censor: front queue plus matching back end.
// Depends on bwc_pkg, bwc_front, bwc_back (and bwc_ram through bwc_back).
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | in_valid / in_stall  | kind, char_code, last
//  output  | out_valid / out_stall| char_out, masked, last_out, found, status
//
// A word or clear item is handled as it is popped; a text item then reads the
// stored words from the word RAM one per cycle, compares each and releases its
// results before the next item is popped. The front queue holds four items, so
// input is accepted while the back end works or the output stalls, until full.
// Reset clears all control state; the word RAM needs no clearing pass.
`default_nettype none
module bad_word_censor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] char_code,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] char_out,
	output logic        masked,
	output logic        last_out,
	output logic        found,
	output logic [1:0]  status
);
	import bwc_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	bwc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.char_code (char_code),
		.last      (last),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	bwc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.masked    (masked),
		.last_out  (last_out),
		.found     (found),
		.status    (status)
	);
endmodule
`default_nettype wire

>>> verif/bad_word_censor_unit_tb.sv
// Self-checking bench for bad_word_censor_unit: streams banned-word loads, clears
// and text through the input channel and checks every output transfer against a
// behavioral censor model kept in the bench. Depends on bwc_pkg and the RTL.
`default_nettype none
module bad_word_censor_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bwc_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] ch;
		logic        last;
	} char_item_t;

	typedef struct {
		logic [15:0] ch;
		logic        m;
		logic        lo;
		logic        f;
		logic [1:0]  st;
	} censored_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = KIND_WORD;
	logic [15:0] char_code = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [15:0] char_out;
	logic masked, last_out, found;
	logic [1:0] status;

	bad_word_censor_unit i_dut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	char_item_t pending_items[$];
	censored_t censored_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	// ---- censor model ----
	logic [15:0] word_store[MAX_WORDS][MAX_WORD_LEN];
	int word_len[MAX_WORDS];
	int word_cnt, load_pos;
	bit load_ovf;
	logic [15:0] recent[MAX_WORD_LEN];
	logic [15:0] held_ch[MAX_WORD_LEN];
	bit held_mask[MAX_WORD_LEN];
	int held_cnt, seen_cnt;
	int blocked[MAX_WORDS];
	bit hit_flag;

	function automatic logic [15:0] lower_ascii(logic [15:0] c);
		return (c >= 16'h41 && c <= 16'h5A) ? c + 16'h20 : c;
	endfunction

	function automatic void emit(logic [15:0] ch, bit m, bit lo, bit f, logic [1:0] st);
		censored_t r;
		r.ch = ch; r.m = m; r.lo = lo; r.f = f; r.st = st;
		censored_q.insert(censored_q.size(), r);
	endfunction

	function automatic void drop_message();
		for (int k = 0; k < MAX_WORD_LEN; k++) begin
			recent[k] = '0; held_ch[k] = '0; held_mask[k] = 0;
		end
		for (int k = 0; k < MAX_WORDS; k++) blocked[k] = 0;
		held_cnt = 0; seen_cnt = 0; hit_flag = 0;
	endfunction

	function automatic void censor_step(logic [1:0] k, logic [15:0] c, logic lst);
		int len;
		bit ok;
		if (k == KIND_WORD) begin
			if (load_pos < MAX_WORD_LEN && word_cnt < MAX_WORDS) begin
				word_store[word_cnt][load_pos] = lower_ascii(c);
				load_pos++;
			end else load_ovf = 1;
			if (lst) begin
				if (load_ovf || word_cnt >= MAX_WORDS) emit(0, 0, 0, 0, ST_REJECT);
				else begin
					word_len[word_cnt] = load_pos;
					blocked[word_cnt] = 0;
					word_cnt++;
					emit(0, 0, 0, 0, ST_STORED);
				end
				load_pos = 0; load_ovf = 0;
			end
		end else if (k == KIND_TEXT) begin
			for (int j = 0; j < MAX_WORD_LEN - 1; j++) recent[j] = recent[j+1];
			recent[MAX_WORD_LEN-1] = lower_ascii(c);
			if (held_cnt >= MAX_WORD_LEN) held_cnt = MAX_WORD_LEN - 1;
			held_ch[held_cnt] = c; held_mask[held_cnt] = 0; held_cnt++;
			if (seen_cnt < MAX_WORD_LEN) seen_cnt++;
			for (int i = 0; i < word_cnt; i++) begin
				if (blocked[i] > 0) begin
					blocked[i]--;
					continue;
				end
				len = word_len[i];
				if (len == 0 || len > seen_cnt || len > held_cnt) continue;
				ok = 1;
				for (int j = 0; j < len; j++)
					if (word_store[i][j] != recent[MAX_WORD_LEN-len+j]) ok = 0;
				if (!ok) continue;
				for (int j = 0; j < len; j++) held_mask[held_cnt-len+j] = 1;
				hit_flag = 1;
				blocked[i] = len - 1;
			end
			if (lst) begin
				for (int j = 0; j < held_cnt; j++)
					emit(held_mask[j] ? ASTERISK : held_ch[j], held_mask[j],
						j + 1 == held_cnt, (j + 1 == held_cnt) && hit_flag, ST_TEXT);
				drop_message();
			end else if (held_cnt >= MAX_WORD_LEN) begin
				emit(held_mask[0] ? ASTERISK : held_ch[0], held_mask[0], 0, 0, ST_TEXT);
				for (int j = 0; j < MAX_WORD_LEN - 1; j++) begin
					held_ch[j] = held_ch[j+1]; held_mask[j] = held_mask[j+1];
				end
				held_cnt--;
			end
		end else if (k == KIND_CLEAR) begin
			for (int i = 0; i < MAX_WORDS; i++) begin
				word_len[i] = 0; blocked[i] = 0;
			end
			word_cnt = 0; load_pos = 0; load_ovf = 0;
		end
	endfunction

	// ---- stimulus builders ----
	string word_bank[$];

	function automatic void queue_char(logic [1:0] k, logic [15:0] c, logic lst);
		char_item_t it;
		it.kind = k; it.ch = c; it.last = lst;
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void queue_word(string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(KIND_WORD, 16'(s[i]), i == s.len() - 1);
		if (s.len() <= MAX_WORD_LEN) word_bank.insert(word_bank.size(), s);
	endfunction

	function automatic void queue_text(string s, bit lst);
		for (int i = 0; i < s.len(); i++)
			queue_char(KIND_TEXT, 16'(s[i]), lst && i == s.len() - 1);
	endfunction

	function automatic void queue_clear();
		queue_char(KIND_CLEAR, 16'($urandom), 1'($urandom_range(0, 1)));
		word_bank.delete();
	endfunction

	function automatic string rand_letters(int n);
		string s;
		string abc;
		int k;
		s = "";
		abc = "abAB-c";
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 5);
			s = {s, abc.substr(k, k)};
		end
		return s;
	endfunction

	function automatic string flip_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'h20;
		return r;
	endfunction

	function automatic void queue_message();
		int pieces;
		pieces = $urandom_range(1, 5);
		for (int p = 0; p < pieces; p++) begin
			if (word_bank.size() > 0 && $urandom_range(0, 2) != 0)
				queue_text(flip_case(word_bank[$urandom_range(0, word_bank.size() - 1)]), 0);
			else if ($urandom_range(0, 9) == 0)
				queue_char(KIND_TEXT, 16'($urandom), 0);
			else
				queue_text(rand_letters($urandom_range(1, 6)), 0);
		end
		queue_text(rand_letters(1), 1);
	endfunction

	// ---- driver ----
	int send_gap = 0;

	// no idling once the end of the stimulus is near
	function automatic bit is_calm();
		return pending_items.size() < 40;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		char_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_WORD;
			char_code <= '0;
			last <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) censor_step(kind, char_code, last);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (!is_calm() && $urandom_range(0, 19) == 0) begin
					in_valid <= 1'b0;
					send_gap <= $urandom_range(0, 16);
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					kind <= it.kind;
					char_code <= it.ch;
					last <= it.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- receiver stall and checker ----
	int stall_left = 0;
	bit held_off = 0;

	always @(posedge clk or negedge arst_n) begin
		censored_t e;
		if (!arst_n) begin
			out_stall <= 1'b1;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (censored_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: char %h status %0d", char_out, status);
				end else begin
					e = censored_q.pop_front();
					if (char_out !== e.ch || masked !== e.m || last_out !== e.lo ||
						found !== e.f || status !== e.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp ch %h m %b lo %b f %b st %0d, ",
								"got ch %h m %b lo %b f %b st %0d"},
								e.ch, e.m, e.lo, e.f, e.st,
								char_out, masked, last_out, found, status);
					end
				end
			end
			// one long hold-off so the front queue fills and stalls the input
			if (!held_off && results_seen >= 40) begin
				held_off <= 1;
				out_stall <= 1'b1;
				stall_left <= HOLD_CYCLES;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!is_calm() && $urandom_range(0, 15) == 0) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 16);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---- watchdog ----
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("bad_word_censor_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int n;
		word_cnt = 0; load_pos = 0; load_ovf = 0;
		for (int i = 0; i < MAX_WORDS; i++) word_len[i] = 0;
		drop_message();

		// directed: case folding, overlapping words, no self overlap
		queue_word("BaD");
		queue_word("aa");
		queue_word("xyzxyzxyzxyzxyzx");       // longest word that fits
		queue_word("abcdefghijklmnopq");      // one too long: rejected
		queue_text("a bAd aaaa", 0);
		queue_char(KIND_TEXT, 16'hFFFF, 0);
		queue_char(KIND_TEXT, 16'h0000, 0);
		queue_char(KIND_NONE, 16'h5A5A, 1);   // ignored kind
		queue_text("XYZXYZXYZXYZXYZXbad", 1);
		queue_text("Z", 1);                   // single-character message
		queue_text("ba", 0);
		queue_clear();                        // list changes mid-message
		queue_word("D!");
		queue_text("d! bad", 1);
		queue_char(KIND_WORD, 16'h41, 0);     // partial word dropped by clear
		queue_clear();
		for (int i = 0; i < MAX_WORDS + 1; i++) queue_word(rand_letters(2));

		while (pending_items.size() < 430) begin
			n = $urandom_range(0, 19);
			if (n == 0 || (n < 3 && word_bank.size() >= MAX_WORDS)) queue_clear();
			else if (n < 6) queue_word(rand_letters($urandom_range(1, 4)));
			else if (n == 6) queue_word(rand_letters($urandom_range(15, 18)));
			else if (n == 7) queue_char(KIND_NONE, 16'($urandom), 1'($urandom_range(0, 1)));
			else if (n == 8) queue_char(KIND_WORD, 16'($urandom), 1);
			else queue_message();
		end
		queue_text("end", 1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() > 0 || in_valid || censored_q.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && censored_q.size() == 0)
			$display("bad_word_censor_unit_tb OK");
		else
			$display("bad_word_censor_unit_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
